### design/evp_pkg.sv
// Types and constants shared by the encoder velocity controller modules.
`default_nettype none
package evp_pkg;

   localparam int MUL_A_W = 53;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = 53;
   localparam int DIV_D_W = 20;

   localparam logic [MUL_B_W-1:0] VEL_SCALE     = 32'd256000000;
   localparam logic [MUL_B_W-1:0] MICROS_PER_S  = 32'd1000000;
   localparam logic [DIV_D_W-1:0] MICROS_DIV    = 20'd1000000;
   localparam logic [34:0]        INTEGRAL_LIM  = 35'd256000;
   localparam logic [31:0]        DUTY_LIM      = 32'd1023;

   localparam logic [31:0] PROP_GAIN_RESET     = 32'd5033165;
   localparam logic [31:0] INTEGRAL_GAIN_RESET = 32'd83886080;
   localparam logic [31:0] DERIV_GAIN_RESET    = 32'd16777;

   localparam logic [1:0] CSR_PROP_GAIN       = 2'd0;
   localparam logic [1:0] CSR_INTEGRAL_GAIN   = 2'd1;
   localparam logic [1:0] CSR_DERIV_GAIN      = 2'd2;
   localparam logic [1:0] CSR_TARGET_VELOCITY = 2'd3;

   typedef enum logic [14:0] {
      ST_IDLE = 15'b000000000000001,
      ST_VMUL = 15'b000000000000010,
      ST_VDIV = 15'b000000000000100,
      ST_WIN  = 15'b000000000001000,
      ST_ADIV = 15'b000000000010000,
      ST_ERR  = 15'b000000000100000,
      ST_IMUL = 15'b000000001000000,
      ST_IDIV = 15'b000000010000000,
      ST_DMUL = 15'b000000100000000,
      ST_DDIV = 15'b000001000000000,
      ST_PMUL = 15'b000010000000000,
      ST_GMUL = 15'b000100000000000,
      ST_EMUL = 15'b001000000000000,
      ST_DRV  = 15'b010000000000000,
      ST_OUT  = 15'b100000000000000
   } state_type;

endpackage
`default_nettype wire

### design/evp_mul.sv
// Bit-serial shift-and-add unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module evp_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [evp_pkg::MUL_A_W-1:0]  a,
   input  wire logic [evp_pkg::MUL_B_W-1:0]  b,
   output logic      [evp_pkg::PROD_W-1:0]   product,
   output logic                              done
);
   localparam int CNT_W = $clog2(evp_pkg::MUL_B_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [evp_pkg::PROD_W-1:0]  acc_ff, acc_in;
   logic [evp_pkg::PROD_W-1:0]  mc_ff, mc_in;
   logic [evp_pkg::MUL_B_W-1:0] mp_ff, mp_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         mc_in   = {{evp_pkg::MUL_B_W{1'b0}}, a};
         mp_in   = b;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = acc_ff + mc_ff;
         end
         mc_in  = {mc_ff[evp_pkg::PROD_W-2:0], 1'b0};
         mp_in  = {1'b0, mp_ff[evp_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(evp_pkg::MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;
endmodule
`default_nettype wire

### design/evp_div.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module evp_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [evp_pkg::DIV_N_W-1:0]  dividend,
   input  wire logic [evp_pkg::DIV_D_W-1:0]  divisor,
   output logic      [evp_pkg::DIV_N_W-1:0]  quotient,
   output logic                              done
);
   localparam int CNT_W = $clog2(evp_pkg::DIV_N_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [evp_pkg::DIV_D_W-1:0] rem_ff, rem_in;
   logic [evp_pkg::DIV_N_W-1:0] q_ff, q_in;
   logic [evp_pkg::DIV_D_W-1:0] dv_ff, dv_in;
   logic [evp_pkg::DIV_D_W:0]   shifted;
   logic [evp_pkg::DIV_D_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dv_in   = dv_ff;
      shifted = {rem_ff, q_ff[evp_pkg::DIV_N_W-1]};
      trial   = shifted - {1'b0, dv_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = dividend;
         dv_in   = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dv_ff}) begin
            rem_in = trial[evp_pkg::DIV_D_W-1:0];
            q_in   = {q_ff[evp_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[evp_pkg::DIV_D_W-1:0];
            q_in   = {q_ff[evp_pkg::DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(evp_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dv_ff  <= dv_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

### design/encoder_velocity_pid.sv
// Velocity PID controller for a quadrature-encoder motor with a moving-average filter.
// The request channel carries one transaction per item: a control sample (action 0)
// with the raw encoder count and the elapsed microseconds, or a ramp tick (action 1).
// Every accepted request produces exactly one response transaction carrying the
// forward and reverse PWM duties and the filtered velocity in ticks per second.
// A control sample with a nonzero elapsed time runs through a bit-serial multiplier
// and a bit-serial divider: four divisions, six multiplications and three
// single-state steps for the window, the error and the drive. Ramp ticks and samples
// with zero elapsed time go from idle straight to the output step. One item is
// processed at a time; req_stall is high while an item is in progress. The response
// sits in an output register, so a stalled receiver holds only the final step of
// the next item. The gain and target registers are written through the csr port
// while the block is idle: a rule for the user that the block does not enforce.
// Synchronous reset restores the register defaults and clears the window,
// integral, previous error, ramped target and held duties.
`default_nettype none
module encoder_velocity_pid #(
   parameter int WINDOW_TAPS = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic [15:0]        req_encoder_count,
   input  wire logic [19:0]        req_elapsed_us,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [9:0]         rsp_pwm_forward,
   output logic      [9:0]         rsp_pwm_reverse,
   output logic signed [23:0]      rsp_velocity_estimate,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int SLOT_W  = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
   localparam int TOTAL_W = 33 + SLOT_W;

   evp_pkg::state_type state_ff, state_in;
   logic        go_ff, go_in;
   logic [31:0] prop_ff, prop_in, igain_ff, igain_in, dgain_ff, dgain_in;
   logic [20:0] tgt_ff, tgt_in, rt_ff, rt_in;
   logic [15:0] count_ff, count_in, prev_count_ff, prev_count_in;
   logic [19:0] elapsed_ff, elapsed_in;
   logic [31:0] win_ff [WINDOW_TAPS];
   logic [31:0] win_in [WINDOW_TAPS];
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [31:0] integ_ff, integ_in, perr_ff, perr_in, vel_ff, vel_in, err_ff, err_in;
   logic [32:0] avg_ff, avg_in;
   logic        neg_ff, neg_in, dneg_ff, dneg_in;
   logic [52:0] dmag_ff, dmag_in;
   logic [63:0] sum_ff, sum_in;
   logic [9:0]  fwd_ff, fwd_in, rev_ff, rev_in;
   logic [23:0] vest_ff, vest_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_fwd_ff, rsp_fwd_in, rsp_rev_ff, rsp_rev_in;
   logic [23:0] rsp_vest_ff, rsp_vest_in;

   logic [evp_pkg::MUL_A_W-1:0] mul_a;
   logic [evp_pkg::MUL_B_W-1:0] mul_b;
   logic [evp_pkg::PROD_W-1:0]  mul_p;
   logic                        mul_start, mul_done;
   logic [evp_pkg::DIV_N_W-1:0] div_n, div_q;
   logic [evp_pkg::DIV_D_W-1:0] div_d;
   logic                        div_start, div_done;

   logic [15:0]        diff16, diff_mag;
   logic [31:0]        err_mag, integ_mag, wv;
   logic [32:0]        ed, ed_mag;
   logic [TOTAL_W-1:0] tot_mag;
   logic [33:0]        e34;
   logic [34:0]        term35, isum;
   logic [60:0]        psat;
   logic [63:0]        psigned, adj;
   logic [31:0]        dr, drc;

   always_comb begin
      diff16    = count_ff - prev_count_ff;
      diff_mag  = diff16[15] ? 16'(~diff16 + 16'd1) : diff16;
      err_mag   = err_ff[31] ? 32'(~err_ff + 32'd1) : err_ff;
      integ_mag = integ_ff[31] ? 32'(~integ_ff + 32'd1) : integ_ff;
      ed        = {err_ff[31], err_ff} - {perr_ff[31], perr_ff};
      ed_mag    = ed[32] ? 33'(~ed + 33'd1) : ed;
      tot_mag   = total_ff[TOTAL_W-1] ? TOTAL_W'(~total_ff + 1'b1) : total_ff;
      wv        = win_ff[slot_ff];
      e34       = {{5{rt_ff[20]}}, rt_ff, 8'b0} - {avg_ff[32], avg_ff};
      term35    = neg_ff ? 35'(~{2'b0, div_q[32:0]} + 35'd1) : {2'b0, div_q[32:0]};
      isum      = {{3{integ_ff[31]}}, integ_ff} + term35;
      psat      = ((|mul_p[evp_pkg::PROD_W-1:61]) || (mul_p[60] && (|mul_p[59:0])))
                  ? {1'b1, 60'b0} : mul_p[60:0];
      psigned   = neg_ff ? 64'(~{3'b0, psat} + 64'd1) : {3'b0, psat};
      adj       = sum_ff[63] ? sum_ff + 64'h0000_0000_FFFF_FFFF : sum_ff;
      dr        = adj[63:32];
      if ($signed(dr) > $signed(evp_pkg::DUTY_LIM)) begin
         drc = evp_pkg::DUTY_LIM;
      end else if ($signed(dr) < -$signed(evp_pkg::DUTY_LIM)) begin
         drc = 32'(~evp_pkg::DUTY_LIM + 32'd1);
      end else begin
         drc = dr;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_n = mul_p[evp_pkg::DIV_N_W-1:0];
      div_d = elapsed_ff;
      case (state_ff)
         evp_pkg::ST_VMUL: begin
            mul_a = evp_pkg::MUL_A_W'(diff_mag);
            mul_b = evp_pkg::VEL_SCALE;
         end
         evp_pkg::ST_IMUL: begin
            mul_a = evp_pkg::MUL_A_W'(err_mag);
            mul_b = evp_pkg::MUL_B_W'(elapsed_ff);
         end
         evp_pkg::ST_DMUL: begin
            mul_a = evp_pkg::MUL_A_W'(ed_mag);
            mul_b = evp_pkg::MICROS_PER_S;
         end
         evp_pkg::ST_PMUL: begin
            mul_a = evp_pkg::MUL_A_W'(err_mag);
            mul_b = prop_ff;
         end
         evp_pkg::ST_GMUL: begin
            mul_a = evp_pkg::MUL_A_W'(integ_mag);
            mul_b = igain_ff;
         end
         evp_pkg::ST_EMUL: begin
            mul_a = dmag_ff;
            mul_b = dgain_ff;
         end
         evp_pkg::ST_ADIV: begin
            div_n = evp_pkg::DIV_N_W'(tot_mag);
            div_d = evp_pkg::DIV_D_W'(WINDOW_TAPS);
         end
         evp_pkg::ST_IDIV: begin
            div_d = evp_pkg::MICROS_DIV;
         end
         default: begin
         end
      endcase
      mul_start = go_ff && (state_ff == evp_pkg::ST_VMUL || state_ff == evp_pkg::ST_IMUL
                  || state_ff == evp_pkg::ST_DMUL || state_ff == evp_pkg::ST_PMUL
                  || state_ff == evp_pkg::ST_GMUL || state_ff == evp_pkg::ST_EMUL);
      div_start = go_ff && (state_ff == evp_pkg::ST_VDIV || state_ff == evp_pkg::ST_ADIV
                  || state_ff == evp_pkg::ST_IDIV || state_ff == evp_pkg::ST_DDIV);
   end

   evp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .product (mul_p),
      .done    (mul_done)
   );

   evp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .quotient (div_q),
      .done     (div_done)
   );

   always_comb begin
      state_in      = state_ff;
      prop_in       = prop_ff;
      igain_in      = igain_ff;
      dgain_in      = dgain_ff;
      tgt_in        = tgt_ff;
      rt_in         = rt_ff;
      count_in      = count_ff;
      prev_count_in = prev_count_ff;
      elapsed_in    = elapsed_ff;
      win_in        = win_ff;
      slot_in       = slot_ff;
      total_in      = total_ff;
      integ_in      = integ_ff;
      perr_in       = perr_ff;
      vel_in        = vel_ff;
      err_in        = err_ff;
      avg_in        = avg_ff;
      neg_in        = neg_ff;
      dneg_in       = dneg_ff;
      dmag_in       = dmag_ff;
      sum_in        = sum_ff;
      fwd_in        = fwd_ff;
      rev_in        = rev_ff;
      vest_in       = vest_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_fwd_in    = rsp_fwd_ff;
      rsp_rev_in    = rsp_rev_ff;
      rsp_vest_in   = rsp_vest_ff;

      if (csr_write) begin
         case (csr_index)
            evp_pkg::CSR_PROP_GAIN:       prop_in  = csr_data;
            evp_pkg::CSR_INTEGRAL_GAIN:   igain_in = csr_data;
            evp_pkg::CSR_DERIV_GAIN:      dgain_in = csr_data;
            evp_pkg::CSR_TARGET_VELOCITY: tgt_in   = csr_data[20:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         evp_pkg::ST_IDLE: begin
            if (req_valid) begin
               count_in   = req_encoder_count;
               elapsed_in = req_elapsed_us;
               if (req_action) begin
                  if ($signed(rt_ff) < $signed(tgt_ff)) begin
                     rt_in = rt_ff + 21'd1;
                  end else if ($signed(rt_ff) > $signed(tgt_ff)) begin
                     rt_in = rt_ff - 21'd1;
                  end
                  state_in = evp_pkg::ST_OUT;
               end else if (req_elapsed_us == 20'd0) begin
                  state_in = evp_pkg::ST_OUT;
               end else begin
                  state_in = evp_pkg::ST_VMUL;
               end
            end
         end
         evp_pkg::ST_VMUL: begin
            if (go_ff) begin
               neg_in        = diff16[15];
               prev_count_in = count_ff;
            end
            if (mul_done) begin
               state_in = evp_pkg::ST_VDIV;
            end
         end
         evp_pkg::ST_VDIV: begin
            if (div_done) begin
               if (!neg_ff) begin
                  vel_in = (|div_q[52:31]) ? 32'h7FFF_FFFF : div_q[31:0];
               end else if ((|div_q[52:32]) || (div_q[31] && (|div_q[30:0]))) begin
                  vel_in = 32'h8000_0000;
               end else begin
                  vel_in = 32'(~div_q[31:0] + 32'd1);
               end
               state_in = evp_pkg::ST_WIN;
            end
         end
         evp_pkg::ST_WIN: begin
            total_in = total_ff - {{(TOTAL_W-32){wv[31]}}, wv}
                       + {{(TOTAL_W-32){vel_ff[31]}}, vel_ff};
            win_in[slot_ff] = vel_ff;
            slot_in  = (slot_ff == SLOT_W'(WINDOW_TAPS - 1)) ? '0 : slot_ff + 1'b1;
            state_in = evp_pkg::ST_ADIV;
         end
         evp_pkg::ST_ADIV: begin
            if (go_ff) begin
               neg_in = total_ff[TOTAL_W-1];
            end
            if (div_done) begin
               avg_in   = neg_ff ? 33'(~div_q[32:0] + 33'd1) : div_q[32:0];
               vest_in  = neg_ff ? 24'(~div_q[31:8] + 24'd1) : div_q[31:8];
               state_in = evp_pkg::ST_ERR;
            end
         end
         evp_pkg::ST_ERR: begin
            if ($signed(e34) > 34'sh0_7FFF_FFFF) begin
               err_in = 32'h7FFF_FFFF;
            end else if ($signed(e34) < -34'sh0_8000_0000) begin
               err_in = 32'h8000_0000;
            end else begin
               err_in = e34[31:0];
            end
            sum_in   = '0;
            state_in = evp_pkg::ST_IMUL;
         end
         evp_pkg::ST_IMUL: begin
            if (go_ff) begin
               neg_in = err_ff[31];
            end
            if (mul_done) begin
               state_in = evp_pkg::ST_IDIV;
            end
         end
         evp_pkg::ST_IDIV: begin
            if (div_done) begin
               if ($signed(isum) > $signed(evp_pkg::INTEGRAL_LIM)) begin
                  integ_in = evp_pkg::INTEGRAL_LIM[31:0];
               end else if ($signed(isum) < -$signed(evp_pkg::INTEGRAL_LIM)) begin
                  integ_in = 32'(~evp_pkg::INTEGRAL_LIM[31:0] + 32'd1);
               end else begin
                  integ_in = isum[31:0];
               end
               state_in = evp_pkg::ST_DMUL;
            end
         end
         evp_pkg::ST_DMUL: begin
            if (go_ff) begin
               dneg_in = ed[32];
            end
            if (mul_done) begin
               state_in = evp_pkg::ST_DDIV;
            end
         end
         evp_pkg::ST_DDIV: begin
            if (div_done) begin
               dmag_in  = div_q;
               state_in = evp_pkg::ST_PMUL;
            end
         end
         evp_pkg::ST_PMUL: begin
            if (go_ff) begin
               neg_in = err_ff[31];
            end
            if (mul_done) begin
               sum_in   = sum_ff + psigned;
               state_in = evp_pkg::ST_GMUL;
            end
         end
         evp_pkg::ST_GMUL: begin
            if (go_ff) begin
               neg_in = integ_ff[31];
            end
            if (mul_done) begin
               sum_in   = sum_ff + psigned;
               state_in = evp_pkg::ST_EMUL;
            end
         end
         evp_pkg::ST_EMUL: begin
            if (go_ff) begin
               neg_in = dneg_ff;
            end
            if (mul_done) begin
               sum_in   = sum_ff + psigned;
               state_in = evp_pkg::ST_DRV;
            end
         end
         evp_pkg::ST_DRV: begin
            if ($signed(drc) > 32'sd0) begin
               fwd_in = drc[9:0];
               rev_in = '0;
            end else begin
               fwd_in = '0;
               rev_in = 10'(~drc + 32'd1);
            end
            perr_in  = err_ff;
            state_in = evp_pkg::ST_OUT;
         end
         evp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fwd_in   = fwd_ff;
               rsp_rev_in   = rev_ff;
               rsp_vest_in  = vest_ff;
               state_in     = evp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = evp_pkg::ST_IDLE;
         end
      endcase
      go_in = (state_in != state_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= evp_pkg::ST_IDLE;
         go_ff         <= 1'b0;
         prop_ff       <= evp_pkg::PROP_GAIN_RESET;
         igain_ff      <= evp_pkg::INTEGRAL_GAIN_RESET;
         dgain_ff      <= evp_pkg::DERIV_GAIN_RESET;
         tgt_ff        <= '0;
         rt_ff         <= '0;
         prev_count_ff <= '0;
         for (int i = 0; i < WINDOW_TAPS; i++) begin
            win_ff[i] <= '0;
         end
         slot_ff       <= '0;
         total_ff      <= '0;
         integ_ff      <= '0;
         perr_ff       <= '0;
         fwd_ff        <= '0;
         rev_ff        <= '0;
         vest_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         go_ff         <= go_in;
         prop_ff       <= prop_in;
         igain_ff      <= igain_in;
         dgain_ff      <= dgain_in;
         tgt_ff        <= tgt_in;
         rt_ff         <= rt_in;
         prev_count_ff <= prev_count_in;
         win_ff        <= win_in;
         slot_ff       <= slot_in;
         total_ff      <= total_in;
         integ_ff      <= integ_in;
         perr_ff       <= perr_in;
         fwd_ff        <= fwd_in;
         rev_ff        <= rev_in;
         vest_ff       <= vest_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      count_ff    <= count_in;
      elapsed_ff  <= elapsed_in;
      vel_ff      <= vel_in;
      err_ff      <= err_in;
      avg_ff      <= avg_in;
      neg_ff      <= neg_in;
      dneg_ff     <= dneg_in;
      dmag_ff     <= dmag_in;
      sum_ff      <= sum_in;
      rsp_fwd_ff  <= rsp_fwd_in;
      rsp_rev_ff  <= rsp_rev_in;
      rsp_vest_ff <= rsp_vest_in;
   end

   assign req_stall             = (state_ff != evp_pkg::ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pwm_forward       = rsp_fwd_ff;
   assign rsp_pwm_reverse       = rsp_rev_ff;
   assign rsp_velocity_estimate = rsp_vest_ff;

   a_integral_bounded: assert property (@(posedge clock) disable iff (reset)
      ($signed(integ_ff) <= 32'sd256000) && ($signed(integ_ff) >= -32'sd256000))
      else $error("Error integral outside its clamp range.");

   a_one_duty_active: assert property (@(posedge clock) disable iff (reset)
      (fwd_ff == 10'd0) || (rev_ff == 10'd0))
      else $error("Forward and reverse duties are both nonzero.");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW_TAPS - 1))
      else $error("Window slot beyond the last tap.");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("Multiplier and divider started together.");

endmodule
`default_nettype wire

### test/encoder_velocity_pid_test.sv
// Self-checking testbench for the encoder velocity PID controller.
`default_nettype none
module encoder_velocity_pid_test;

   localparam int TAPS = 7;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [9:0]         fwd;
      logic [9:0]         rev;
      logic signed [23:0] vel;
   } duty_type;

   typedef struct {
      logic               action;
      logic [15:0]        count;
      logic [19:0]        elapsed;
      logic               known;
      duty_type           result;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [15:0] req_encoder_count = '0;
   logic [19:0] req_elapsed_us = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [9:0] rsp_pwm_forward;
   logic [9:0] rsp_pwm_reverse;
   logic signed [23:0] rsp_velocity_estimate;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   encoder_velocity_pid dut (.*);

   // Controller state as predicted by the testbench.
   logic [31:0] kp, ki, kd;
   longint target, ramp, integ, last_err, win_sum;
   logic [15:0] last_count;
   longint win [TAPS];
   int slot;
   logic [19:0] duties;

   duty_type expected_duties[$];
   int mismatches = 0;
   longint cycles = 0;
   bit no_idle = 1'b0;

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint scaled_gain(logic [31:0] g, longint v);
      logic [127:0] p, m;
      m = (v < 0) ? 128'(-v) : 128'(v);
      p = 128'(g) * m;
      if (p > (128'd1 << 60)) p = 128'd1 << 60;
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic duty_type current_duties();
      duty_type d;
      d.fwd = duties[9:0];
      d.rev = duties[19:10];
      d.vel = 24'(longint'(win_sum / TAPS) / 256);
      return d;
   endfunction

   function automatic void reset_controller();
      kp = evp_pkg::PROP_GAIN_RESET;
      ki = evp_pkg::INTEGRAL_GAIN_RESET;
      kd = evp_pkg::DERIV_GAIN_RESET;
      target = 0; ramp = 0; integ = 0; last_err = 0; win_sum = 0;
      last_count = '0; slot = 0; duties = '0;
      for (int i = 0; i < TAPS; i++) win[i] = 0;
   endfunction

   function automatic duty_type predict_duties(logic act, logic [15:0] cnt, logic [19:0] el);
      longint dt, diff, v, avg, err, der, drive;
      logic [15:0] raw;
      dt = longint'(el);
      if (act) begin
         if (ramp < target) ramp++;
         else if (ramp > target) ramp--;
         return current_duties();
      end
      if (dt == 0) return current_duties();
      raw = cnt - last_count;
      diff = longint'($signed(raw));
      last_count = cnt;
      v = sat32(diff * 256000000 / dt);
      win_sum = win_sum - win[slot] + v;
      win[slot] = v;
      slot = (slot + 1) % TAPS;
      avg = win_sum / TAPS;
      err = sat32(ramp * 256 - avg);
      integ = integ + err * dt / 1000000;
      if (integ > 256000) integ = 256000;
      if (integ < -256000) integ = -256000;
      der = (err - last_err) * 1000000 / dt;
      last_err = err;
      drive = (scaled_gain(kp, err) + scaled_gain(ki, integ) + scaled_gain(kd, der))
              / 64'sd4294967296;
      if (drive > 1023) drive = 1023;
      if (drive < -1023) drive = -1023;
      if (drive > 0) duties = 20'(drive);
      else duties = 20'((-drive) << 10);
      return current_duties();
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_duties.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response transaction");
         end else begin
            duty_type e;
            e = expected_duties.pop_front();
            if (e.fwd !== rsp_pwm_forward || e.rev !== rsp_pwm_reverse
                || e.vel !== rsp_velocity_estimate) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           e.fwd, e.rev, e.vel, rsp_pwm_forward,
                           rsp_pwm_reverse, rsp_velocity_estimate);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !no_idle && ($urandom_range(99) < 31);
   end

   task automatic write_register(logic [1:0] idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         evp_pkg::CSR_PROP_GAIN: kp = value;
         evp_pkg::CSR_INTEGRAL_GAIN: ki = value;
         evp_pkg::CSR_DERIV_GAIN: kd = value;
         evp_pkg::CSR_TARGET_VELOCITY: target = longint'($signed(value[20:0]));
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic send_sample(logic act, logic [15:0] cnt, logic [19:0] el,
                              logic known, duty_type given);
      duty_type p;
      while (!no_idle && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_encoder_count <= cnt;
      req_elapsed_us <= el;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_duties(act, cnt, el);
      expected_duties.push_back(known ? given : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_duties.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic random_phase(int n, int ramp_pct);
      logic [15:0] cnt;
      for (int i = 0; i < n; i++) begin
         int r;
         r = $urandom_range(99);
         if (r < ramp_pct) send_sample(1'b1, 16'($urandom), 20'($urandom), 1'b0, '0);
         else if (r < ramp_pct + 4)
            send_sample(1'b0, 16'($urandom), 20'($urandom), 1'b0, '0);
         else if (r < ramp_pct + 6) send_sample(1'b0, 16'($urandom), '0, 1'b0, '0);
         else begin
            cnt = last_count + 16'($urandom_range(0, 200)) - 16'd100;
            send_sample(1'b0, cnt, 20'($urandom_range(500, 4000)), 1'b0, '0);
         end
      end
   endtask

   stim_type directed[] = '{
      '{1'b0, 16'd0,     20'd0,       1'b1, '0},
      '{1'b1, 16'hFFFF,  20'hFFFFF,   1'b1, '0},
      '{1'b0, 16'd0,     20'd2000,    1'b1, '0},
      '{1'b0, 16'd100,   20'd2000,    1'b0, '0},
      '{1'b0, 16'hFFFF,  20'd1,       1'b0, '0},
      '{1'b0, 16'h7FFF,  20'd1,       1'b0, '0},
      '{1'b0, 16'h8000,  20'hFFFFF,   1'b0, '0},
      '{1'b0, 16'h8000,  20'd0,       1'b0, '0},
      '{1'b0, 16'h0000,  20'd1,       1'b0, '0},
      '{1'b1, 16'd0,     20'd0,       1'b0, '0},
      '{1'b0, 16'h1234,  20'd2000,    1'b0, '0},
      '{1'b0, 16'h5555,  20'hAAAAA,   1'b0, '0},
      '{1'b0, 16'hAAAA,  20'h55555,   1'b0, '0}
   };

   initial begin
      reset_controller();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_sample(directed[i].action, directed[i].count, directed[i].elapsed,
                     directed[i].known, directed[i].result);
      drain();
      write_register(evp_pkg::CSR_TARGET_VELOCITY, 32'h000FFFFF);
      write_register(evp_pkg::CSR_PROP_GAIN, 32'hFFFFFFFF);
      write_register(evp_pkg::CSR_INTEGRAL_GAIN, 32'hFFFFFFFF);
      write_register(evp_pkg::CSR_DERIV_GAIN, 32'hFFFFFFFF);
      random_phase(250, 40);
      drain();
      write_register(evp_pkg::CSR_TARGET_VELOCITY, 32'h00100000);
      write_register(evp_pkg::CSR_PROP_GAIN, 32'd0);
      write_register(evp_pkg::CSR_INTEGRAL_GAIN, 32'd0);
      write_register(evp_pkg::CSR_DERIV_GAIN, 32'd0);
      random_phase(250, 40);
      drain();
      write_register(evp_pkg::CSR_TARGET_VELOCITY,
                     32'($urandom_range(0, 4000)) - 32'd2000);
      write_register(evp_pkg::CSR_PROP_GAIN, evp_pkg::PROP_GAIN_RESET);
      write_register(evp_pkg::CSR_INTEGRAL_GAIN, evp_pkg::INTEGRAL_GAIN_RESET);
      write_register(evp_pkg::CSR_DERIV_GAIN, evp_pkg::DERIV_GAIN_RESET);
      no_idle = 1'b1;
      random_phase(300, 25);
      no_idle = 1'b0;
      random_phase(300, 25);
      drain();
      write_register(evp_pkg::CSR_TARGET_VELOCITY, $urandom);
      write_register(evp_pkg::CSR_PROP_GAIN, $urandom);
      write_register(evp_pkg::CSR_INTEGRAL_GAIN, $urandom);
      write_register(evp_pkg::CSR_DERIV_GAIN, $urandom);
      random_phase(340, 30);
      drain();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
design/evp_pkg.sv
design/evp_mul.sv
design/evp_div.sv
design/encoder_velocity_pid.sv
test/encoder_velocity_pid_test.sv
